@@ src/plac_pkg.sv @@
package plac_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int ENTRY_INDEX_W = 4;
  localparam int RAW_W = 16;
  localparam int ORIGIN_W = 24;
  localparam int STEP_W = 16;
  localparam int USED_W = 5;
  localparam int CAL_W = 32;
  localparam int FRAC_BITS = 8;

  // base never exceeds origin plus 29 steps, so 26 bits cover every depth
  localparam int BASE_W = 26;
  localparam int ACC_W = CAL_W + 3;

  localparam int QUOT_W = 32;
  localparam int DIV_STEP_BITS = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_USED = 2'd2;

  localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 24'd0;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd256;
  localparam logic [USED_W-1:0] USED_RESET = 5'd6;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CONV = 1'b1;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_PASS = 2'd1,
    ST_FLAT = 2'd2,
    ST_SAT = 2'd3
  } status_t;

  typedef struct packed {
    status_t st;
    logic neg;
    logic [BASE_W-1:0] base;
  } side_t;

endpackage

@@ src/plac_table.sv @@
module plac_table #(
  parameter int TABLE_DEPTH = plac_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic in_kind,
  input  logic [plac_pkg::ENTRY_INDEX_W-1:0] in_index,
  input  logic [plac_pkg::RAW_W-1:0] in_value,
  input  logic [plac_pkg::RAW_W-1:0] in_sample,
  input  logic [plac_pkg::USED_W-1:0] used_entries,
  output logic sel_valid,
  output logic sel_pass,
  output logic [IDX_W-1:0] sel_index,
  output logic [plac_pkg::RAW_W-1:0] sel_lo,
  output logic [plac_pkg::RAW_W-1:0] sel_hi,
  output logic [plac_pkg::RAW_W-1:0] sel_sample
);
  import plac_pkg::*;

  localparam int WX_W = IDX_W + ENTRY_INDEX_W;

  logic [RAW_W-1:0] tbl [TABLE_DEPTH];
  logic [WX_W-1:0] wr_ext;
  logic [7:0] used_ext;
  logic [CNT_W-1:0] n;

  logic [TABLE_DEPTH-1:0] ge_c;
  logic pass_c;
  logic v1;
  logic pass1;
  logic [TABLE_DEPTH-1:0] ge1;
  logic [RAW_W-1:0] smp1;
  logic [IDX_W-1:0] idx_c;

  assign wr_ext = WX_W'(in_index);

  always_ff @(posedge clk) begin
    if (en && in_valid && in_kind == KIND_WRITE && wr_ext < WX_W'(TABLE_DEPTH)) begin
      tbl[wr_ext[IDX_W-1:0]] <= in_value;
    end
  end

  // clamp the entry count to 2..TABLE_DEPTH
  always_comb begin
    used_ext = 8'(used_entries);
    if (used_ext < 8'd2) begin
      n = CNT_W'(2);
    end else if (used_ext > 8'(TABLE_DEPTH)) begin
      n = CNT_W'(TABLE_DEPTH);
    end else begin
      n = CNT_W'(used_ext);
    end
  end

  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      ge_c[j] = (tbl[j] >= in_sample) && (CNT_W'(j) < n);
    end
    pass_c = in_sample <= tbl[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && in_kind == KIND_CONV;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass1 <= pass_c;
      ge1 <= ge_c;
      smp1 <= in_sample;
    end
  end

  // first qualifying entry from index 1 up, else the last one in use
  always_comb begin
    idx_c = IDX_W'(n - CNT_W'(1));
    for (int j = TABLE_DEPTH - 1; j >= 1; j--) begin
      if (ge1[j]) begin
        idx_c = IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (en) begin
      sel_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_pass <= pass1;
      sel_index <= idx_c;
      sel_lo <= tbl[idx_c - IDX_W'(1)];
      sel_hi <= tbl[idx_c];
      sel_sample <= smp1;
    end
  end

endmodule

@@ src/plac_div.sv @@
module plac_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [plac_pkg::QUOT_W-1:0] in_num,
  input  logic [plac_pkg::RAW_W-1:0] in_den,
  input  plac_pkg::side_t in_side,
  output logic out_valid,
  output logic [plac_pkg::QUOT_W-1:0] out_quot,
  output plac_pkg::side_t out_side
);
  import plac_pkg::*;

  localparam int NST = QUOT_W / DIV_STEP_BITS;

  logic vld [NST];
  logic [RAW_W-1:0] rem [NST];
  logic [QUOT_W-1:0] qn [NST];
  logic [RAW_W-1:0] den [NST];
  side_t sd [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic cur_vld;
    logic [RAW_W-1:0] cur_rem;
    logic [QUOT_W-1:0] cur_qn;
    logic [RAW_W-1:0] cur_den;
    side_t cur_sd;
    logic [RAW_W-1:0] rem_c;
    logic [QUOT_W-1:0] qn_c;
    logic [RAW_W:0] r;

    if (s == 0) begin : g_first
      assign cur_vld = in_valid;
      assign cur_rem = '0;
      assign cur_qn = in_num;
      assign cur_den = in_den;
      assign cur_sd = in_side;
    end else begin : g_next
      assign cur_vld = vld[s-1];
      assign cur_rem = rem[s-1];
      assign cur_qn = qn[s-1];
      assign cur_den = den[s-1];
      assign cur_sd = sd[s-1];
    end

    // shift numerator bits into the remainder, quotient bits in at the bottom
    always_comb begin
      rem_c = cur_rem;
      qn_c = cur_qn;
      r = '0;
      for (int b = 0; b < DIV_STEP_BITS; b++) begin
        r = {rem_c, qn_c[QUOT_W-1]};
        qn_c = {qn_c[QUOT_W-2:0], 1'b0};
        if (r >= {1'b0, cur_den}) begin
          rem_c = RAW_W'(r - {1'b0, cur_den});
          qn_c[0] = 1'b1;
        end else begin
          rem_c = r[RAW_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= rem_c;
        qn[s] <= qn_c;
        den[s] <= cur_den;
        sd[s] <= cur_sd;
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign out_quot = qn[NST-1];
  assign out_side = sd[NST-1];

endmodule

@@ src/piecewise_linear_adc_calibration.sv @@
// Piecewise-linear ADC calibration. A request with tuser 0 writes one table
// entry (a raw reading per evenly spaced true value); a request with tuser 1
// converts a raw sample and yields one result: the calibrated value with 8
// fraction bits and a status (interpolated, passthrough, flat segment,
// saturated). The block takes one request per cycle while the output is not
// stalled; a conversion's result passes through the input register, the entry
// compare, the segment select, the multiply stage, a divider pipelined over 8
// stages of 4 quotient bits and the output register.
// All stages move together, so a stalled output holds the whole pipeline.
// A table entry that a conversion reads must have been written first.
module piecewise_linear_adc_calibration #(
  parameter int TABLE_DEPTH = plac_pkg::TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // entry_index [3:0], entry_value [19:4], sample [35:20], zero [39:36]
  input  logic [39:0] s_tdata,
  // kind [0]
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // calibrated [31:0]
  output logic [31:0] m_tdata,
  // status [1:0]
  output logic [1:0] m_tuser,
  input  logic cfg_we,
  input  logic [plac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [plac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import plac_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [ORIGIN_W-1:0] origin_value;
  logic [STEP_W-1:0] step_value;
  logic [USED_W-1:0] used_entries;

  logic adv;

  logic v0;
  logic kind0;
  logic [ENTRY_INDEX_W-1:0] idx0;
  logic [RAW_W-1:0] val0;
  logic [RAW_W-1:0] smp0;

  logic sel_valid;
  logic sel_pass;
  logic [IDX_W-1:0] sel_index;
  logic [RAW_W-1:0] sel_lo;
  logic [RAW_W-1:0] sel_hi;
  logic [RAW_W-1:0] sel_sample;

  logic signed [RAW_W:0] d_c;
  logic [RAW_W-1:0] den_c;
  side_t side_c;
  logic [BASE_W-1:0] seg_c;

  logic v3;
  logic [QUOT_W-1:0] num3;
  logic [RAW_W-1:0] den3;
  side_t side3;

  logic dv;
  logic [QUOT_W-1:0] quot;
  side_t dside;

  logic signed [ACC_W-1:0] acc_c;
  logic [CAL_W-1:0] cal_next;
  status_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_value <= ORIGIN_RESET;
      step_value <= STEP_RESET;
      used_entries <= USED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN: origin_value <= cfg_data[ORIGIN_W-1:0];
        CFG_STEP: step_value <= cfg_data[STEP_W-1:0];
        CFG_USED: used_entries <= cfg_data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind0 <= s_tuser[0];
      idx0 <= s_tdata[3:0];
      val0 <= s_tdata[19:4];
      smp0 <= s_tdata[35:20];
    end
  end

  plac_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(v0),
    .in_kind(kind0),
    .in_index(idx0),
    .in_value(val0),
    .in_sample(smp0),
    .used_entries(used_entries),
    .sel_valid(sel_valid),
    .sel_pass(sel_pass),
    .sel_index(sel_index),
    .sel_lo(sel_lo),
    .sel_hi(sel_hi),
    .sel_sample(sel_sample)
  );

  // segment slope sign and size, base of the segment
  always_comb begin
    d_c = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo});
    den_c = d_c[RAW_W] ? RAW_W'(-d_c) : d_c[RAW_W-1:0];
    seg_c = BASE_W'(origin_value) + BASE_W'((sel_index - IDX_W'(1)) * step_value);
    side_c.neg = d_c[RAW_W];
    if (sel_pass) begin
      side_c.st = ST_PASS;
      side_c.base = BASE_W'({sel_sample, {FRAC_BITS{1'b0}}});
    end else if (d_c == '0) begin
      side_c.st = ST_FLAT;
      side_c.base = seg_c;
    end else begin
      side_c.st = ST_INTERP;
      side_c.base = seg_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num3 <= (sel_sample - sel_lo) * step_value;
      den3 <= den_c;
      side3 <= side_c;
    end
  end

  plac_div u_div (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(v3),
    .in_num(num3),
    .in_den(den3),
    .in_side(side3),
    .out_valid(dv),
    .out_quot(quot),
    .out_side(dside)
  );

  always_comb begin
    if (dside.neg) begin
      acc_c = $signed(ACC_W'(dside.base)) - $signed(ACC_W'(quot));
    end else begin
      acc_c = $signed(ACC_W'(dside.base)) + $signed(ACC_W'(quot));
    end
    case (dside.st)
      ST_PASS: begin
        cal_next = CAL_W'(dside.base);
        st_next = ST_PASS;
      end
      ST_FLAT: begin
        cal_next = '1;
        st_next = ST_FLAT;
      end
      default: begin
        if (acc_c < 0) begin
          cal_next = '0;
          st_next = ST_SAT;
        end else if (acc_c[ACC_W-1:CAL_W] != '0) begin
          cal_next = '1;
          st_next = ST_SAT;
        end else begin
          cal_next = acc_c[CAL_W-1:0];
          st_next = ST_INTERP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= cal_next;
      m_tuser <= st_next;
    end
  end

endmodule
